FILE: design/rc4_pkg.sv
package rc4_pkg;

  localparam int SBOX_DEPTH        = 256;
  localparam int BYTE_W            = 8;
  localparam int KEY_W             = 64;
  localparam int KEY_LEN_W         = 5;
  localparam int KEY_POS_W         = 4;
  localparam int CFG_IDX_W         = 2;
  localparam int MAX_KEY_BYTES_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic OP_REKEY = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA_RD_I,
    ST_DATA_RD_J,
    ST_DATA_WR_J,
    ST_SCHED_START,
    ST_SCHED_RD_A,
    ST_SCHED_WR_D,
    ST_SCHED_WR_A
  } rc4_state_t;

endpackage

FILE: design/rc4_in_if.sv
interface rc4_in_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  rc4_pkg::byte_t       data_byte;
  logic                 message_start;

  modport source (output valid, opcode, data_byte, message_start, input ready);
  modport sink   (input valid, opcode, data_byte, message_start, output ready);
endinterface

FILE: design/rc4_out_if.sv
interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

FILE: design/rc4_cfg_if.sv
interface rc4_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rc4_pkg::CFG_IDX_W-1:0]    index;
  logic [rc4_pkg::KEY_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rc4_stream_cipher.sv
// RC4 stream cipher. A word with opcode 1 returns data_byte XOR the next keystream
// byte; message_start zeroes i and j first, while the permutation carries over. A
// word with opcode 0 reloads the identity permutation, runs the key schedule with
// the key held in the configuration registers and clears i and j; it gives no
// result. The permutation sits in one 256 x 8 RAM with a single write port, so a
// data word steps through accept, read S[i], read S[j] and write S[i], and write
// S[j], and a rekey through a start step and then a read, write, write per entry.
// Per-entry valid bits give the identity after reset and at rekey, so no clearing
// pass is needed. The input is not ready while a word is in flight. A finished
// result may wait in the output register; the next data word is still accepted,
// but holds after its first read until that result is taken.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rc4_cfg_if.sink      cfg,
  rc4_in_if.sink       din,
  rc4_out_if.source    dout
);

  localparam int DW = rc4_pkg::BYTE_W;

  rc4_pkg::rc4_state_t state, state_next;

  logic [rc4_pkg::KEY_W-1:0]     key_low_bytes;
  logic [rc4_pkg::KEY_W-1:0]     key_high_bytes;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_length;

  rc4_pkg::byte_t index_i;
  rc4_pkg::byte_t index_j;
  rc4_pkg::byte_t acc;
  rc4_pkg::byte_t sched_idx;
  rc4_pkg::byte_t held;
  rc4_pkg::byte_t data_q;
  logic           ks_from_held;
  logic [rc4_pkg::KEY_POS_W-1:0] key_pos;

  logic           out_valid;
  rc4_pkg::byte_t out_byte;

  logic [DW-1:0]               sbox [rc4_pkg::SBOX_DEPTH];
  logic [rc4_pkg::SBOX_DEPTH-1:0] sbox_valid;
  rc4_pkg::byte_t rd_data;
  rc4_pkg::byte_t rd_addr_q;
  logic           rd_hit;
  logic           byp;
  rc4_pkg::byte_t byp_data;
  rc4_pkg::byte_t rd_val;

  logic           wr_en;
  rc4_pkg::byte_t wr_addr;
  rc4_pkg::byte_t wr_data;
  rc4_pkg::byte_t rd_addr;
  logic           vclear;

  logic           accept;
  rc4_pkg::byte_t i_start;
  rc4_pkg::byte_t j_start;
  rc4_pkg::byte_t k_addr;
  rc4_pkg::byte_t acc_next;
  rc4_pkg::byte_t key_byte;
  logic [2*rc4_pkg::KEY_W-1:0]   key_all;
  logic [rc4_pkg::KEY_LEN_W-1:0] eff_len;
  logic [rc4_pkg::KEY_POS_W-1:0] key_last;
  logic [rc4_pkg::KEY_POS_W-1:0] key_pos_next;
  logic           out_free;

  assign cfg.ready     = 1'b1;
  assign din.ready     = (state == rc4_pkg::ST_IDLE);
  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;

  assign accept   = din.valid && din.ready;
  assign out_free = !out_valid || dout.ready;
  assign i_start  = din.message_start ? '0 : index_i;
  assign j_start  = din.message_start ? '0 : index_j;

  assign rd_val   = byp ? byp_data : (rd_hit ? rd_data : rd_addr_q);
  assign k_addr   = held + rd_val;

  assign key_all  = {key_high_bytes, key_low_bytes};
  assign key_byte = key_all[key_pos*DW +: DW];
  assign acc_next = acc + rd_val + key_byte;

  always_comb begin
    if (key_length == '0) begin
      eff_len = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length > rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
      eff_len = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_length;
    end
  end

  assign key_last     = rc4_pkg::KEY_POS_W'(eff_len - rc4_pkg::KEY_LEN_W'(1));
  assign key_pos_next = (key_pos == key_last) ? '0 : key_pos + 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = index_i;
    wr_data    = rd_val;
    rd_addr    = index_i;
    vclear     = 1'b0;
    case (state)
      rc4_pkg::ST_IDLE: begin
        rd_addr = i_start + 1'b1;
        if (accept) begin
          if (din.opcode == rc4_pkg::OP_REKEY) begin
            state_next = rc4_pkg::ST_SCHED_START;
            vclear     = 1'b1;
          end else begin
            state_next = rc4_pkg::ST_DATA_RD_I;
          end
        end
      end
      rc4_pkg::ST_DATA_RD_I: begin
        rd_addr = index_i;
        if (out_free) begin
          rd_addr    = index_j + rd_val;
          state_next = rc4_pkg::ST_DATA_RD_J;
        end
      end
      rc4_pkg::ST_DATA_RD_J: begin
        wr_en      = 1'b1;
        wr_addr    = index_i;
        wr_data    = rd_val;
        rd_addr    = k_addr;
        state_next = rc4_pkg::ST_DATA_WR_J;
      end
      rc4_pkg::ST_DATA_WR_J: begin
        wr_en      = 1'b1;
        wr_addr    = index_j;
        wr_data    = held;
        state_next = rc4_pkg::ST_IDLE;
      end
      rc4_pkg::ST_SCHED_START: begin
        rd_addr    = sched_idx;
        state_next = rc4_pkg::ST_SCHED_RD_A;
      end
      rc4_pkg::ST_SCHED_RD_A: begin
        rd_addr    = acc_next;
        state_next = rc4_pkg::ST_SCHED_WR_D;
      end
      rc4_pkg::ST_SCHED_WR_D: begin
        wr_en      = 1'b1;
        wr_addr    = sched_idx;
        wr_data    = rd_val;
        state_next = rc4_pkg::ST_SCHED_WR_A;
      end
      rc4_pkg::ST_SCHED_WR_A: begin
        wr_en   = 1'b1;
        wr_addr = acc;
        wr_data = held;
        rd_addr = sched_idx + 1'b1;
        if (sched_idx == '1) begin
          state_next = rc4_pkg::ST_IDLE;
        end else begin
          state_next = rc4_pkg::ST_SCHED_RD_A;
        end
      end
      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      index_i <= '0;
      index_j <= '0;
    end else begin
      case (state)
        rc4_pkg::ST_IDLE: begin
          if (accept) begin
            data_q    <= din.data_byte;
            acc       <= '0;
            sched_idx <= '0;
            key_pos   <= '0;
            if (din.opcode == rc4_pkg::OP_REKEY) begin
              index_i <= '0;
              index_j <= '0;
            end else begin
              index_i <= i_start + 1'b1;
              index_j <= j_start;
            end
          end
        end
        rc4_pkg::ST_DATA_RD_I: begin
          if (out_free) begin
            held    <= rd_val;
            index_j <= index_j + rd_val;
          end
        end
        rc4_pkg::ST_DATA_RD_J: begin
          ks_from_held <= (k_addr == index_j);
        end
        rc4_pkg::ST_SCHED_RD_A: begin
          held <= rd_val;
          acc  <= acc_next;
        end
        rc4_pkg::ST_SCHED_WR_A: begin
          sched_idx <= sched_idx + 1'b1;
          key_pos   <= key_pos_next;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rc4_pkg::ST_DATA_WR_J) begin
      out_valid <= 1'b1;
      out_byte  <= data_q ^ (ks_from_held ? held : rd_val);
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_bytes  <= '0;
      key_high_bytes <= '0;
      key_length     <= rc4_pkg::KEY_LEN_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        rc4_pkg::REG_KEY_LOW:    key_low_bytes  <= cfg.data;
        rc4_pkg::REG_KEY_HIGH:   key_high_bytes <= cfg.data;
        rc4_pkg::REG_KEY_LENGTH: key_length     <= cfg.data[rc4_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // permutation RAM: invalid entries read as their own address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sbox[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || vclear) begin
      sbox_valid <= '0;
    end else if (wr_en) begin
      sbox_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data   <= sbox[rd_addr];
    rd_hit    <= sbox_valid[rd_addr];
    rd_addr_q <= rd_addr;
    byp       <= wr_en && (wr_addr == rd_addr);
    byp_data  <= wr_data;
  end

endmodule
